/* rtl/mtlb_pkg.sv */
// Shared types, codes and constants of the MIPS32-style joint TLB.
`default_nettype none
package mtlb_pkg;

    // Default table depth
    localparam int ENTRY_COUNT_DEF = 16;

    // Operation codes
    localparam logic [2:0] OP_WR_REG   = 3'd0;
    localparam logic [2:0] OP_RD_REG   = 3'd1;
    localparam logic [2:0] OP_PROBE    = 3'd2;
    localparam logic [2:0] OP_WR_IDX   = 3'd3;
    localparam logic [2:0] OP_WR_RAND  = 3'd4;
    localparam logic [2:0] OP_RD_ENTRY = 3'd5;
    localparam logic [2:0] OP_XLATE    = 3'd6;

    // Staging register selectors
    localparam logic [2:0] SEL_INDEX    = 3'd0;
    localparam logic [2:0] SEL_LO_EVEN  = 3'd1;
    localparam logic [2:0] SEL_LO_ODD   = 3'd2;
    localparam logic [2:0] SEL_PAGEMASK = 3'd3;
    localparam logic [2:0] SEL_HI       = 3'd4;

    // Field masks and constants
    localparam logic [31:0] VPN_FIELD_MASK = 32'hFFFF_E000;
    localparam logic [31:0] HI_G_BIT       = 32'h0000_1000;
    localparam logic [31:0] LO_G_BIT       = 32'h0000_0001;
    localparam logic [31:0] PFN_MASK       = 32'h3FFF_FFC0;
    localparam logic [31:0] MIN_PAGE_MASK  = 32'hFFFF_F000;
    localparam logic [31:0] MISS_FLAG      = 32'h8000_0000;
    localparam logic [31:0] MASK_ROUND     = 32'h0000_1FFF;
    localparam logic [32:0] PAGE_STEP      = 33'h0_0000_2000;
    localparam logic [31:0] BUS_MASK_RST   = 32'hFFFF_FFFF;

    // Input item
    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  reg_sel;
        logic [31:0] write_data;
        logic [31:0] virt_addr;
    } t_tlb_in;

    // Result item
    typedef struct packed {
        logic [31:0] read_data;
        logic        hit;
        logic [3:0]  entry_index;
        logic [31:0] phys_addr;
        logic        dirty_bit;
        logic        valid_bit;
        logic        global_page;
    } t_tlb_out;

    // One stored TLB entry
    typedef struct packed {
        logic [31:0] pagemask;
        logic [31:0] hi;
        logic [31:0] lo_even;
        logic [31:0] lo_odd;
    } t_entry;

endpackage
`default_nettype wire

/* rtl/mtlb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module mtlb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/mips32_tlb_engine.sv */
// Top level of the MIPS32-style joint TLB: staging registers, sequencer and entry table.
`default_nettype none
// Usage:
//   Command channel: an item (t_tlb_in on i_cmd) is taken at a rising edge with
//   start high and busy low. Each item gives exactly one result on o_rsp, shown
//   for one cycle while o_done is high; the receiver cannot hold it off.
//   Config: i_cfg_we / i_cfg_wdata write the bus address mask, taken at once.
//   Steps per operation:
//     register write/read, indexed/random write, unknown op: result in the next
//     cycle, and busy stays low, so one such item can be taken every cycle.
//     read entry: one RAM read, then the copy back to the staging registers.
//     probe: scan state only; translate: scan state, then S_XLAT. The entry table sits
//     in one RAM with a registered read; the scan reads one entry per
//     cycle and stops at the first (lowest numbered) match.
//   Reset (synchronous, active low) clears the staging registers, the victim
//   counter and one valid flag per entry; entries never written read as zero,
//   so no clearing pass is needed. The bus mask resets to all ones.
module mips32_tlb_engine
    #(
    parameter int ENTRY_COUNT = mtlb_pkg::ENTRY_COUNT_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire mtlb_pkg::t_tlb_in i_cmd,
    output logic                   o_done,
    output mtlb_pkg::t_tlb_out     o_rsp,
    input  wire logic              i_cfg_we,
    input  wire logic [31:0]       i_cfg_wdata
);
    import mtlb_pkg::*;

    localparam int IW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int CW = IW + 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRY_COUNT - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_XLAT, S_RDENT} t_state;

    t_state      r_state;
    logic [31:0] r_index, r_hi, r_lo_even, r_lo_odd, r_mask, r_bus_mask;
    logic [IW-1:0] r_victim;
    logic [2:0]  r_op;
    logic [31:0] r_vaddr;
    logic [CW-1:0] r_scan;
    logic [IW-1:0] r_q_idx;
    logic        r_q_vld;
    logic [ENTRY_COUNT-1:0] r_vld;
    t_entry      r_ent;
    logic [IW-1:0] r_ent_idx;
    logic        r_done;
    t_tlb_out    r_rsp;

    logic        accept;
    logic        is_wr, is_rand, ram_we;
    logic [31:0] wr_idx;
    logic [IW-1:0] waddr, raddr;
    t_entry      wr_ent, ram_q, q_ent;
    logic [31:0] cmp_mask;
    logic        match;
    logic [32:0] size, size_m1;
    logic [31:0] xl_lo, xl_pa;
    logic [31:0] rd_reg;
    logic [IW-1:0] victim_nxt;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // write decode: indexed falls back to random when the miss flag is set
    always_comb begin
        is_wr   = (i_cmd.op == OP_WR_IDX) || (i_cmd.op == OP_WR_RAND);
        is_rand = (i_cmd.op == OP_WR_RAND) || ((i_cmd.op == OP_WR_IDX) && r_index[31]);
        wr_idx  = is_rand ? 32'(r_victim) : r_index;
        ram_we  = accept && is_wr && (wr_idx < 32'(ENTRY_COUNT));
        waddr   = wr_idx[IW-1:0];
        victim_nxt = (r_victim == LAST_IDX) ? '0 : r_victim + IW'(1);
    end

    // global bit folds from both Lo words into the stored Hi word
    always_comb begin
        wr_ent.pagemask = r_mask;
        wr_ent.hi       = r_hi | (((r_lo_even & r_lo_odd & LO_G_BIT) != 0) ? HI_G_BIT : '0);
        wr_ent.lo_even  = r_lo_even & ~LO_G_BIT;
        wr_ent.lo_odd   = r_lo_odd & ~LO_G_BIT;
    end

    // read address: entry for read-entry, scan pointer while scanning
    always_comb begin
        raddr = '0;
        case (r_state)
            S_IDLE: begin
                if ((i_cmd.op == OP_RD_ENTRY) && (r_index < 32'(ENTRY_COUNT))) begin
                    raddr = r_index[IW-1:0];
                end
            end
            S_SCAN: begin
                if (r_scan < CW'(ENTRY_COUNT)) begin
                    raddr = r_scan[IW-1:0];
                end
            end
            default: raddr = '0;
        endcase
    end

    mtlb_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (ENTRY_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (wr_ent),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    // never-written entries read as zero
    assign q_ent = r_q_vld ? ram_q : '0;

    // entry match against the address under search
    always_comb begin
        cmp_mask = ~(q_ent.pagemask + MASK_ROUND);
        match = (((r_vaddr & VPN_FIELD_MASK) & cmp_mask)
                 == ((q_ent.hi & VPN_FIELD_MASK) & cmp_mask))
             && (q_ent.hi[12] || (q_ent.hi[7:0] == r_hi[7:0]));
    end

    // translation from the captured entry
    always_comb begin
        size    = ({1'b0, r_ent.pagemask} + PAGE_STEP) >> 1;
        size_m1 = size - 33'd1;
        xl_lo   = ((r_vaddr & size[31:0]) == '0) ? r_ent.lo_even : r_ent.lo_odd;
        xl_pa   = (((xl_lo & PFN_MASK) << 6) + ((r_vaddr & MIN_PAGE_MASK) & size_m1[31:0]))
                & r_bus_mask;
    end

    // staging register read mux
    always_comb begin
        case (i_cmd.reg_sel)
            SEL_INDEX:    rd_reg = r_index;
            SEL_LO_EVEN:  rd_reg = r_lo_even;
            SEL_LO_ODD:   rd_reg = r_lo_odd;
            SEL_PAGEMASK: rd_reg = r_mask;
            SEL_HI:       rd_reg = r_hi;
            default:      rd_reg = '0;
        endcase
    end

    // sequencer, staging registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_index    <= '0;
            r_hi       <= '0;
            r_lo_even  <= '0;
            r_lo_odd   <= '0;
            r_mask     <= '0;
            r_victim   <= '0;
            r_vld      <= '0;
            r_bus_mask <= BUS_MASK_RST;
            r_done     <= 1'b0;
            r_q_vld    <= 1'b0;
        end else begin
            r_done  <= 1'b0;
            r_q_idx <= raddr;
            r_q_vld <= r_vld[raddr];

            if (i_cfg_we) begin
                r_bus_mask <= i_cfg_wdata;
            end
            if (ram_we) begin
                r_vld[waddr] <= 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op  <= i_cmd.op;
                        r_rsp <= '0;
                        case (i_cmd.op)
                            OP_WR_REG: begin
                                r_done <= 1'b1;
                                case (i_cmd.reg_sel)
                                    SEL_INDEX:    r_index   <= i_cmd.write_data;
                                    SEL_LO_EVEN:  r_lo_even <= i_cmd.write_data;
                                    SEL_LO_ODD:   r_lo_odd  <= i_cmd.write_data;
                                    SEL_PAGEMASK: r_mask    <= i_cmd.write_data;
                                    SEL_HI:       r_hi      <= i_cmd.write_data;
                                    default: ;
                                endcase
                            end
                            OP_RD_REG: begin
                                r_done          <= 1'b1;
                                r_rsp.read_data <= rd_reg;
                            end
                            OP_PROBE: begin
                                r_vaddr <= r_hi;
                                r_scan  <= CW'(1);
                                r_state <= S_SCAN;
                            end
                            OP_XLATE: begin
                                r_vaddr <= i_cmd.virt_addr;
                                r_scan  <= CW'(1);
                                r_state <= S_SCAN;
                            end
                            OP_WR_IDX, OP_WR_RAND: begin
                                r_done <= 1'b1;
                                if (is_rand) begin
                                    r_victim <= victim_nxt;
                                end
                            end
                            OP_RD_ENTRY: begin
                                if (r_index < 32'(ENTRY_COUNT)) begin
                                    r_state <= S_RDENT;
                                end else begin
                                    r_done <= 1'b1;
                                end
                            end
                            default: r_done <= 1'b1;
                        endcase
                    end
                end

                // one entry compared per cycle, lowest match wins
                S_SCAN: begin
                    r_scan <= r_scan + CW'(1);
                    if (match) begin
                        if (r_op == OP_PROBE) begin
                            r_index             <= 32'(r_q_idx);
                            r_rsp.hit           <= 1'b1;
                            r_rsp.entry_index   <= 4'(32'(r_q_idx));
                            r_rsp.global_page   <= q_ent.hi[12];
                            r_done              <= 1'b1;
                            r_state             <= S_IDLE;
                        end else begin
                            r_ent     <= q_ent;
                            r_ent_idx <= r_q_idx;
                            r_state   <= S_XLAT;
                        end
                    end else if (r_q_idx == LAST_IDX) begin
                        if (r_op == OP_PROBE) begin
                            r_index <= MISS_FLAG;
                        end
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end

                S_XLAT: begin
                    r_rsp.hit         <= 1'b1;
                    r_rsp.entry_index <= 4'(32'(r_ent_idx));
                    r_rsp.phys_addr   <= xl_pa;
                    r_rsp.dirty_bit   <= xl_lo[2];
                    r_rsp.valid_bit   <= xl_lo[1];
                    r_rsp.global_page <= r_ent.hi[12];
                    r_done            <= 1'b1;
                    r_state           <= S_IDLE;
                end

                // copy entry back, global bit split into both Lo words
                S_RDENT: begin
                    r_mask <= q_ent.pagemask;
                    if (q_ent.hi[12]) begin
                        r_hi      <= q_ent.hi & ~HI_G_BIT;
                        r_lo_even <= q_ent.lo_even | LO_G_BIT;
                        r_lo_odd  <= q_ent.lo_odd | LO_G_BIT;
                    end else begin
                        r_hi      <= q_ent.hi;
                        r_lo_even <= q_ent.lo_even;
                        r_lo_odd  <= q_ent.lo_odd;
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // table writes happen only on the edge that takes the item
    a_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !busy && start)
        else $error("table write outside item acceptance");

    // victim pointer stays inside the table
    a_victim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_victim) < ENTRY_COUNT)
        else $error("victim pointer out of range");

    // a search item always leaves the block busy on the next cycle
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ((i_cmd.op == OP_PROBE) || (i_cmd.op == OP_XLATE))) |=> busy)
        else $error("search started without going busy");

    // a result without a hit carries no translation
    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_rsp.hit) |-> (o_rsp.phys_addr == '0) && !o_rsp.dirty_bit
            && !o_rsp.valid_bit && !o_rsp.global_page)
        else $error("miss result carries translation fields");

endmodule
`default_nettype wire
